### sv/jse_pkg.sv
// Package for the JSON string escaper: item kinds, queue entry type,
// character constants and the hex digit function.
// No dependencies.
package jse_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned STEP_W = 3;
  localparam int unsigned Q_DEPTH = 2;

  localparam logic [BYTE_W-1:0] CTRL_LIMIT  = 8'h20;
  localparam logic [BYTE_W-1:0] PRINT_LIMIT = 8'h7E;

  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LB    = 8'h62;
  localparam logic [BYTE_W-1:0] CH_LF_E  = 8'h66;
  localparam logic [BYTE_W-1:0] CH_LN    = 8'h6E;
  localparam logic [BYTE_W-1:0] CH_LR    = 8'h72;
  localparam logic [BYTE_W-1:0] CH_LT    = 8'h74;
  localparam logic [BYTE_W-1:0] CH_LU    = 8'h75;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;

  localparam logic [STEP_W-1:0] STEP_TWO_LAST = 3'd1;
  localparam logic [STEP_W-1:0] STEP_HEX_LAST = 3'd5;

  localparam logic [1:0] KIND_PASS = 2'd0;
  localparam logic [1:0] KIND_TWO  = 2'd1;
  localparam logic [1:0] KIND_HEX  = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] data;
  } jse_entry_t;

  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
    logic [BYTE_W-1:0] res;
    if (nib < 4'd10) begin
      res = 8'h30 + {4'd0, nib};
    end else begin
      res = 8'h37 + {4'd0, nib};
    end
    return res;
  endfunction

endpackage

### sv/jse_if.sv
// Valid/ready channel interfaces for the JSON string escaper.
// Depends on jse_pkg for the byte width.
interface jse_in_if import jse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface jse_out_if import jse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

### sv/jse_front.sv
// Front end of the escaper: classifies one raw byte into a queue entry.
// Depends on jse_pkg for the entry type and character constants.
module jse_front import jse_pkg::*; (
  input  logic [BYTE_W-1:0] raw_byte,
  output jse_entry_t        entry
);

  always_comb begin
    entry.kind = KIND_TWO;
    entry.data = raw_byte;
    unique case (raw_byte)
      CH_QUOTE: entry.data = CH_QUOTE;
      CH_BSL:   entry.data = CH_BSL;
      CH_BS:    entry.data = CH_LB;
      CH_FF:    entry.data = CH_LF_E;
      CH_LF:    entry.data = CH_LN;
      CH_CR:    entry.data = CH_LR;
      CH_TAB:   entry.data = CH_LT;
      default: begin
        if (raw_byte < CTRL_LIMIT || raw_byte > PRINT_LIMIT) begin
          entry.kind = KIND_HEX;
        end else begin
          entry.kind = KIND_PASS;
        end
      end
    endcase
  end

endmodule

### sv/jse_queue.sv
// Short first-in first-out queue of classified entries between front and back.
// Depends on jse_pkg for the entry type.
module jse_queue import jse_pkg::*; #(
  parameter int unsigned DEPTH = Q_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  jse_entry_t push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output jse_entry_t pop_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  jse_entry_t        slot_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### sv/jse_back.sv
// Back end of the escaper: expands one queued entry into its run of output
// beats, one byte per beat. Depends on jse_pkg.
module jse_back import jse_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  jse_entry_t        q_data,
  output logic              beat_valid,
  input  logic              beat_ready,
  output logic [BYTE_W-1:0] beat_byte,
  output logic              beat_last
);

  jse_entry_t        cur_r;
  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              fire, take;

  assign beat_valid = busy_r;
  assign fire       = busy_r && beat_ready;
  assign q_ready    = !busy_r || (beat_ready && beat_last);
  assign take       = q_valid && q_ready;

  always_comb begin
    beat_byte = cur_r.data;
    beat_last = 1'b1;
    unique case (cur_r.kind)
      KIND_TWO: begin
        beat_byte = (step_r == '0) ? CH_BSL : cur_r.data;
        beat_last = (step_r == STEP_TWO_LAST);
      end
      KIND_HEX: begin
        beat_last = (step_r == STEP_HEX_LAST);
        unique case (step_r)
          3'd0:    beat_byte = CH_BSL;
          3'd1:    beat_byte = CH_LU;
          3'd4:    beat_byte = hex_digit(cur_r.data[7:4]);
          3'd5:    beat_byte = hex_digit(cur_r.data[3:0]);
          default: beat_byte = CH_ZERO;
        endcase
      end
      default: begin
        beat_byte = cur_r.data;
        beat_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (take) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (fire) begin
      busy_nxt = !beat_last;
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_r <= q_data;
    end
  end

endmodule

### sv/json_string_escaper.sv
// Top level of the JSON string escaper: front classifier, entry queue and
// back-end run expander. Depends on jse_pkg, jse_if, jse_front, jse_queue, jse_back.
//
// Usage: in_ch carries one raw byte per beat; out_ch carries the escaped
// text one byte per beat, with run_last high on the final byte of the run
// for each input byte. A run is 1 byte for plain printable bytes, 2 bytes
// for quote, backslash and the five named control characters, and 6 bytes
// (\u00XX, upper-case hex) for every other byte below 0x20 or above 0x7E.
// An input beat's entry is registered in the queue, then in the back-end
// entry register, before the first byte of its run is offered on out_ch.
// Throughput: one output byte per cycle while out_ch.ready is high and the
// queue holds entries, so plain bytes then flow at one per cycle.
// The queue of QDEPTH entries lets the input keep taking bytes while a run
// is being expanded; in_ch.ready drops only when the queue is full.
// When the receiver stalls, the current byte is held unchanged on out_ch.
// Synchronous reset empties the queue and drops any run in progress.
module json_string_escaper import jse_pkg::*; #(
  parameter int unsigned QDEPTH = Q_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  jse_in_if.sink     in_ch,
  jse_out_if.source  out_ch
);

  jse_entry_t front_entry;
  jse_entry_t q_entry;
  logic       q_valid;
  logic       q_ready;

  jse_front u_front (
    .raw_byte (in_ch.in_byte),
    .entry    (front_entry)
  );

  jse_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_ch.valid),
    .push_ready (in_ch.ready),
    .push_data  (front_entry),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_entry)
  );

  jse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_data     (q_entry),
    .beat_valid (out_ch.valid),
    .beat_ready (out_ch.ready),
    .beat_byte  (out_ch.out_byte),
    .beat_last  (out_ch.run_last)
  );

endmodule
